FILE: sv/sactf_pkg.sv
// Shared constants, types and row formats of the cache tag store.
// Used by every module of the block; no dependencies.
package sactf_pkg;

  // Address and cache geometry (16 KB cache, 16-byte minimum line)
  localparam int ADDR_W     = 26;
  localparam int CACHE_LOG2 = 14;
  localparam int TAG_W      = 16;
  localparam int WAY_W      = 4;
  localparam int SET_W      = 10;
  localparam int COL_W      = 4;
  localparam int NUM_COLS   = 16;
  localparam int ROW_W      = 6;
  localparam int NUM_ROWS   = 64;
  localparam int GEO_W      = 3;

  // Configuration port
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS      = 1'd1;

  localparam logic [GEO_W-1:0] LSL_MIN   = 3'd4;
  localparam logic [GEO_W-1:0] LSL_RESET = 3'd4;
  localparam logic [GEO_W-1:0] WL_MAX    = 3'd4;
  localparam logic [GEO_W-1:0] WL_RESET  = 3'd2;

  // One tag memory row: sixteen lines, valid bit and tag each
  typedef struct packed {
    logic [NUM_COLS-1:0]            vld;
    logic [NUM_COLS-1:0][TAG_W-1:0] tag;
  } tag_row_t;

  // One pointer memory row: FIFO pointers of sixteen sets
  typedef logic [NUM_COLS-1:0][WAY_W-1:0] ptr_row_t;

  // Lookup carried from acceptance to the compare stage
  typedef struct packed {
    logic [SET_W-1:0] set;
    logic [TAG_W-1:0] tag;
    logic [GEO_W-1:0] wl;
    logic [COL_W-1:0] col_base;
    logic [ROW_W-1:0] tag_row;
  } lookup_t;

  // Outcome of the compare stage
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    tag_row_t         tag_wr;
    ptr_row_t         ptr_wr;
  } match_t;

endpackage

FILE: sv/sactf_tag_mem.sv
// Tag memory: 64 rows of sixteen lines (valid + tag), registered read.
// Per-row valid flops stand in for clearing the valid bits. Uses sactf_pkg.
module sactf_tag_mem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [sactf_pkg::ROW_W-1:0] rd_row,
  output sactf_pkg::tag_row_t      rd_data,
  input  logic                     wr_en,
  input  logic [sactf_pkg::ROW_W-1:0] wr_row,
  input  sactf_pkg::tag_row_t      wr_data
);

  sactf_pkg::tag_row_t                   mem [sactf_pkg::NUM_ROWS];
  sactf_pkg::tag_row_t                   rd_q_r;
  logic [sactf_pkg::NUM_ROWS-1:0]        row_vld_r;
  logic                                  rd_ok_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_row];
    end
  end

  // Row valid flags: a row never written reads as all lines invalid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_vld_r[rd_row];
      end
    end
  end

  assign rd_data.vld = rd_q_r.vld & {sactf_pkg::NUM_COLS{rd_ok_r}};
  assign rd_data.tag = rd_q_r.tag;

endmodule

FILE: sv/sactf_ptr_mem.sv
// FIFO pointer memory: 64 rows of sixteen 4-bit pointers, registered read.
// Per-row valid flops give the all-zero reset value. Uses sactf_pkg.
module sactf_ptr_mem (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [sactf_pkg::ROW_W-1:0] rd_row,
  output sactf_pkg::ptr_row_t      rd_data,
  input  logic                     wr_en,
  input  logic [sactf_pkg::ROW_W-1:0] wr_row,
  input  sactf_pkg::ptr_row_t      wr_data
);

  sactf_pkg::ptr_row_t                   mem [sactf_pkg::NUM_ROWS];
  sactf_pkg::ptr_row_t                   rd_q_r;
  logic [sactf_pkg::NUM_ROWS-1:0]        row_vld_r;
  logic                                  rd_ok_r;

  // Storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_row];
    end
  end

  // Row valid flags: an unwritten row reads as all pointers zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_row] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= row_vld_r[rd_row];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

FILE: sv/sactf_match.sv
// Way compare and FIFO replacement for one lookup: parallel tag compare,
// lowest-way select, and the rows to write back on a miss. Uses sactf_pkg.
module sactf_match (
  input  sactf_pkg::lookup_t  lk,
  input  sactf_pkg::tag_row_t trow,
  input  sactf_pkg::ptr_row_t prow,
  output sactf_pkg::match_t   res
);

  logic [sactf_pkg::WAY_W-1:0]    way_mask;
  logic [sactf_pkg::NUM_COLS-1:0] member;
  logic [sactf_pkg::NUM_COLS-1:0] hit_vec;
  logic [sactf_pkg::COL_W-1:0]    hit_col;
  logic [sactf_pkg::WAY_W-1:0]    fill_way;
  logic [sactf_pkg::COL_W-1:0]    fill_col;
  logic [sactf_pkg::COL_W-1:0]    set_col;

  // Ways of the set sit in an aligned block of columns
  assign way_mask = sactf_pkg::WAY_W'((5'd1 << lk.wl) - 5'd1);
  assign set_col  = lk.set[sactf_pkg::COL_W-1:0];

  always_comb begin
    for (int c = 0; c < sactf_pkg::NUM_COLS; c++) begin
      member[c]  = (sactf_pkg::COL_W'(c) & ~way_mask) == lk.col_base;
      hit_vec[c] = member[c] && trow.vld[c] && (trow.tag[c] == lk.tag);
    end
  end

  // Lowest matching column wins
  always_comb begin
    hit_col = '0;
    for (int c = sactf_pkg::NUM_COLS - 1; c >= 0; c--) begin
      if (hit_vec[c]) begin
        hit_col = sactf_pkg::COL_W'(c);
      end
    end
  end

  // Replacement victim from the set's FIFO pointer
  assign fill_way = prow[set_col] & way_mask;
  assign fill_col = lk.col_base | fill_way;

  always_comb begin
    res.hit    = |hit_vec;
    res.way    = res.hit ? (hit_col & way_mask) : fill_way;
    res.tag_wr = trow;
    res.tag_wr.vld[fill_col] = 1'b1;
    res.tag_wr.tag[fill_col] = lk.tag;
    res.ptr_wr = prow;
    res.ptr_wr[set_col] = (fill_way + 4'd1) & way_mask;
  end

endmodule

FILE: sv/set_assoc_cache_tag_fifo_top.sv
// Set-associative cache tag store with FIFO replacement, top level.
// Instantiates sactf_tag_mem, sactf_ptr_mem and sactf_match; uses sactf_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_address) takes one 26-bit byte
//   address per transfer. Result channel (out_valid/out_ready) returns hit,
//   the way that hit or was filled, and the set index, one per input, in order.
//   cfg_we/cfg_index/cfg_data write line_size_log2 (index 0) and ways_log2
//   (index 1); write them only while idle and reset the block afterwards.
// Pipeline:
//   An address is accepted, its tag and pointer rows are read from the two
//   memories in the next cycle, and the result is registered at the end of
//   that cycle if the output register is free. Each item holds the lookup
//   stage for both steps (read, then compare and write back of the same
//   row), so a new address is accepted only once the last one is done.
// Reset:
//   Synchronous, active low. Valid bits and FIFO pointers read as zero at
//   once (per-row flags), so no clearing pass is needed; geometry returns to
//   16-byte lines and 4 ways.
// Stall:
//   A result waiting on out_ready is held in the output register; one more
//   item can be looked up meanwhile, then in_ready stays low until it drains.
module set_assoc_cache_tag_fifo_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sactf_pkg::ADDR_W-1:0]      in_address,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [sactf_pkg::WAY_W-1:0]       out_way_used,
  output logic [sactf_pkg::SET_W-1:0]       out_set_number,
  input  logic                              cfg_we,
  input  logic [sactf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sactf_pkg::CFG_W-1:0]       cfg_data
);

  logic [sactf_pkg::GEO_W-1:0] lsl_r;
  logic [sactf_pkg::GEO_W-1:0] wl_r;
  logic [sactf_pkg::GEO_W-1:0] eff_l;
  logic [sactf_pkg::GEO_W-1:0] eff_w;
  logic [3:0]                  idx_bits;
  logic [sactf_pkg::SET_W-1:0] set_mask;
  logic [sactf_pkg::SET_W-1:0] base_line;
  sactf_pkg::lookup_t          lk_nxt;
  sactf_pkg::lookup_t          lk_r;
  sactf_pkg::tag_row_t         trow;
  sactf_pkg::ptr_row_t         prow;
  sactf_pkg::match_t           res;
  logic                        busy_r;
  logic                        accept;
  logic                        done;
  logic                        out_valid_r;
  logic                        out_hit_r;
  logic [sactf_pkg::WAY_W-1:0] out_way_r;
  logic [sactf_pkg::SET_W-1:0] out_set_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsl_r <= sactf_pkg::LSL_RESET;
      wl_r  <= sactf_pkg::WL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sactf_pkg::CFG_LINE_SIZE: lsl_r <= cfg_data;
        sactf_pkg::CFG_WAYS:      wl_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address split under the clamped geometry
  always_comb begin
    eff_l    = (lsl_r < sactf_pkg::LSL_MIN) ? sactf_pkg::LSL_MIN : lsl_r;
    eff_w    = (wl_r > sactf_pkg::WL_MAX) ? sactf_pkg::WL_MAX : wl_r;
    idx_bits = 4'(sactf_pkg::CACHE_LOG2) - {1'b0, eff_l} - {1'b0, eff_w};
    set_mask = sactf_pkg::SET_W'((11'd1 << idx_bits) - 11'd1);
    lk_nxt.set = sactf_pkg::SET_W'(in_address >> eff_l) & set_mask;
    lk_nxt.tag = sactf_pkg::TAG_W'(in_address >> (4'(sactf_pkg::CACHE_LOG2) - {1'b0, eff_w}));
    lk_nxt.wl  = eff_w;
    base_line  = sactf_pkg::SET_W'(lk_nxt.set << eff_w);
    lk_nxt.col_base = base_line[sactf_pkg::COL_W-1:0];
    lk_nxt.tag_row  = base_line[sactf_pkg::SET_W-1:sactf_pkg::COL_W];
  end

  // Handshake: one lookup in flight; it completes when the output frees up
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  assign done     = busy_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lk_r <= lk_nxt;
    end
  end

  // Memories: read on transfer, write back on a completed miss
  sactf_tag_mem u_tag_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_row  (lk_nxt.tag_row),
    .rd_data (trow),
    .wr_en   (done && !res.hit),
    .wr_row  (lk_r.tag_row),
    .wr_data (res.tag_wr)
  );

  sactf_ptr_mem u_ptr_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_row  (lk_nxt.set[sactf_pkg::SET_W-1:sactf_pkg::COL_W]),
    .rd_data (prow),
    .wr_en   (done && !res.hit),
    .wr_row  (lk_r.set[sactf_pkg::SET_W-1:sactf_pkg::COL_W]),
    .wr_data (res.ptr_wr)
  );

  sactf_match u_match (
    .lk   (lk_r),
    .trow (trow),
    .prow (prow),
    .res  (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r <= res.hit;
      out_way_r <= res.way;
      out_set_r <= lk_r.set;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_set_number = out_set_r;

endmodule

FILE: bench/tb.sv
// Self-checking bench for set_assoc_cache_tag_fifo_top: a table of directed
// accesses, then random phases across line sizes and way counts, each result
// checked against its table entry or a behavioral tag store. Needs sactf_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES    = 1 << (sactf_pkg::CACHE_LOG2 - 4);
  localparam int MAX_WAYS = 1 << sactf_pkg::WAY_W;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct packed {
    logic                        hit;
    logic [sactf_pkg::WAY_W-1:0] way;
    logic [sactf_pkg::SET_W-1:0] set_num;
  } lookup_res_t;

  typedef enum logic {ROW_ACCESS, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t                       kind;
    logic [sactf_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [sactf_pkg::CFG_W-1:0]     reg_val;
    logic [sactf_pkg::ADDR_W-1:0]    addr;
    bit                              typed;
    lookup_res_t                     res;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [sactf_pkg::ADDR_W-1:0]    in_address = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_hit;
  logic [sactf_pkg::WAY_W-1:0]     out_way_used;
  logic [sactf_pkg::SET_W-1:0]     out_set_number;
  logic                            cfg_we = 1'b0;
  logic [sactf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sactf_pkg::CFG_W-1:0]     cfg_data = '0;

  // Behavioral copy of the tag store and geometry registers
  logic [sactf_pkg::TAG_W-1:0]     line_tag [LINES];
  logic                            line_vld [LINES];
  logic [sactf_pkg::WAY_W-1:0]     fifo_ptr [LINES];
  logic [sactf_pkg::GEO_W-1:0]     geo_lsl = sactf_pkg::LSL_RESET;
  logic [sactf_pkg::GEO_W-1:0]     geo_wl = sactf_pkg::WL_RESET;

  lookup_res_t           lookups_due[$];
  stim_row_t             dir_rows[$];
  int                    fail_count = 0;
  int                    burst_left = 0;

  set_assoc_cache_tag_fifo_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_set_number (out_set_number),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Lookup with FIFO fill on miss; updates the local tag store
  function automatic lookup_res_t tag_lookup(logic [sactf_pkg::ADDR_W-1:0] addr);
    int unsigned lsl, wl, ib, nways, base, ln, way, k;
    logic [31:0] set_idx, tag;
    bit found;
    lookup_res_t res;
    lsl = 32'(geo_lsl);
    if (lsl < 4) lsl = 4;
    if (lsl > 7) lsl = 7;
    wl = 32'(geo_wl);
    if (wl > 4) wl = 4;
    while (wl > 0 && ((1 << wl) > MAX_WAYS || wl + lsl > sactf_pkg::CACHE_LOG2)) wl--;
    ib = (sactf_pkg::CACHE_LOG2 > lsl + wl) ? sactf_pkg::CACHE_LOG2 - lsl - wl : 0;
    nways = 1 << wl;
    set_idx = (32'(addr) >> lsl) & ((32'd1 << ib) - 1);
    if (lsl + ib >= sactf_pkg::ADDR_W) tag = '0;
    else tag = (32'(addr) >> (lsl + ib)) & ((32'd1 << (sactf_pkg::ADDR_W - lsl - ib)) - 1);
    base = (set_idx << wl) % LINES;
    found = 1'b0;
    way = 0;
    // lowest matching way wins
    for (k = 0; k < nways; k++) begin
      ln = (base + k) % LINES;
      if (!found && line_vld[ln] && line_tag[ln] == tag[sactf_pkg::TAG_W-1:0]) begin
        found = 1'b1;
        way = k;
      end
    end
    // miss: fill the way under the set's pointer, pointer wraps at way count
    if (!found) begin
      way = fifo_ptr[set_idx % LINES] & (nways - 1);
      ln = (base + way) % LINES;
      line_tag[ln] = tag[sactf_pkg::TAG_W-1:0];
      line_vld[ln] = 1'b1;
      fifo_ptr[set_idx % LINES] = sactf_pkg::WAY_W'((way + 1) & (nways - 1));
    end
    res.hit = found;
    res.way = way[sactf_pkg::WAY_W-1:0];
    res.set_num = set_idx[sactf_pkg::SET_W-1:0];
    return res;
  endfunction

  function automatic void add_access(logic [sactf_pkg::ADDR_W-1:0] addr);
    stim_row_t r;
    r.kind = ROW_ACCESS;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.addr = addr;
    r.typed = 1'b0;
    r.res = '0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic [sactf_pkg::ADDR_W-1:0] addr, logic hit,
                                      logic [sactf_pkg::WAY_W-1:0] way,
                                      logic [sactf_pkg::SET_W-1:0] set_num);
    stim_row_t r;
    r.kind = ROW_ACCESS;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.addr = addr;
    r.typed = 1'b1;
    r.res.hit = hit;
    r.res.way = way;
    r.res.set_num = set_num;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(logic [sactf_pkg::CFG_IDX_W-1:0] idx,
                                    logic [sactf_pkg::CFG_W-1:0] val);
    stim_row_t r;
    r.kind = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    r.addr = '0;
    r.typed = 1'b0;
    r.res = '0;
    dir_rows.push_back(r);
  endfunction

  // One address transfer; entered and left at a falling edge
  task automatic send_access(logic [sactf_pkg::ADDR_W-1:0] addr, bit typed,
                             lookup_res_t res);
    lookup_res_t pred;
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = tag_lookup(addr);
    lookups_due.push_back(typed ? res : pred);
    @(negedge clk);
  endtask

  // Stop sending and wait until every lookup has returned
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [sactf_pkg::CFG_IDX_W-1:0] idx,
                           logic [sactf_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sactf_pkg::CFG_LINE_SIZE: geo_lsl = val;
      sactf_pkg::CFG_WAYS:      geo_wl = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Sender bursts: random lengths, random gaps, the odd full drain
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    if ($urandom_range(0, 299) == 0) wait_idle();
  endtask

  // Receiver stall pattern: modes switch after runs of random length
  initial begin
    int mode, left, hold, cyc;
    bit rdy;
    mode = 0;
    left = 0;
    hold = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      cyc++;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = cyc[0];
        2: rdy = ($urandom_range(0, 9) < 7);
        default: begin
          if (hold > 0) begin
            hold--;
            rdy = 1'b0;
          end else begin
            hold = $urandom_range(3, 15);
            rdy = 1'b1;
          end
        end
      endcase
      out_ready <= rdy;
    end
  end

  // Result check against the oldest pending lookup
  always @(posedge clk) begin : result_check
    lookup_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lookups_due.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result hit=%0d way=%0d set=%0d", $time,
                 out_hit, out_way_used, out_set_number);
      end else begin
        want = lookups_due.pop_front();
        if (out_hit !== want.hit) begin
          fail_count++;
          $display("%0t: hit expected %0d got %0d", $time, want.hit, out_hit);
        end
        if (out_way_used !== want.way) begin
          fail_count++;
          $display("%0t: way_used expected %0d got %0d", $time, want.way, out_way_used);
        end
        if (out_set_number !== want.set_num) begin
          fail_count++;
          $display("%0t: set_number expected %0d got %0d", $time, want.set_num,
                   out_set_number);
        end
      end
    end
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // Stimulus
  initial begin
    logic [sactf_pkg::ADDR_W-1:0] recent [32];
    logic [sactf_pkg::ADDR_W-1:0] addr;
    logic [13:0]                  tag_pool [6];
    logic [7:0]                   set_pool [4];
    logic [sactf_pkg::GEO_W-1:0]  ph_lsl [3];
    logic [sactf_pkg::GEO_W-1:0]  ph_wl [3];
    int                           recent_wr, ph, n, i, pick;
    lookup_res_t                  none;

    none = '0;
    recent_wr = 0;
    ph_lsl = '{3'd7, 3'd5, 3'd1};
    ph_wl = '{3'd0, 3'd3, 3'd6};
    for (i = 0; i < 32; i++) recent[i] = '0;
    for (i = 0; i < LINES; i++) begin
      line_tag[i] = '0;
      line_vld[i] = 1'b0;
      fifo_ptr[i] = '0;
    end

    // Directed table; reset geometry is 16-byte lines, 4 ways
    add_checked(26'h0000000, 1'b0, 4'd0, 10'd0);     // cold miss
    add_checked(26'h0000000, 1'b1, 4'd0, 10'd0);     // same line hits
    add_checked(26'h3FFFFFF, 1'b0, 4'd0, 10'd255);   // top address
    add_checked(26'h3FFFFFF, 1'b1, 4'd0, 10'd255);
    add_checked(26'h0001000, 1'b0, 4'd1, 10'd0);     // fill the rest of set 0
    add_checked(26'h0002000, 1'b0, 4'd2, 10'd0);
    add_checked(26'h0003000, 1'b0, 4'd3, 10'd0);
    add_checked(26'h0004000, 1'b0, 4'd0, 10'd0);     // pointer wraps, evicts way 0
    add_checked(26'h0000000, 1'b0, 4'd1, 10'd0);     // evicted tag misses again
    add_checked(26'h000300F, 1'b1, 4'd3, 10'd0);     // offset bits ignored
    // largest lines, most ways; old contents read under new geometry
    add_write(sactf_pkg::CFG_LINE_SIZE, 3'd7);
    add_write(sactf_pkg::CFG_WAYS, 3'd4);
    add_checked(26'h3FFFFFF, 1'b0, 4'd0, 10'd7);
    add_checked(26'h3FFFFFF, 1'b1, 4'd0, 10'd7);
    add_access(26'h0000380);
    add_access(26'h0000000);
    // out-of-range values clamp: line size up to 16 bytes, ways down to 16
    add_write(sactf_pkg::CFG_LINE_SIZE, 3'd0);
    add_write(sactf_pkg::CFG_WAYS, 3'd7);
    add_access(26'h00003FF);
    add_access(26'h0000000);
    // direct mapped, then two ways: both ways of one set carry the same tag
    add_write(sactf_pkg::CFG_LINE_SIZE, 3'd4);
    add_write(sactf_pkg::CFG_WAYS, 3'd0);
    add_access((26'd5 << 14) | (26'd6 << 4));
    add_access((26'd5 << 14) | (26'd7 << 4));
    add_write(sactf_pkg::CFG_WAYS, 3'd1);
    add_checked((26'd5 << 13) | (26'd3 << 4), 1'b1, 4'd0, 10'd3); // lowest way
    add_access((26'd6 << 13) | (26'd3 << 4));

    // Reset
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_cfg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      end else begin
        send_access(dir_rows[i].addr, dir_rows[i].typed, dir_rows[i].res);
        pace();
      end
    end

    // Random phases, geometry changed between them without a reset
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      if (ph < 3) begin
        write_cfg(sactf_pkg::CFG_LINE_SIZE, ph_lsl[ph]);
        write_cfg(sactf_pkg::CFG_WAYS, ph_wl[ph]);
      end else begin
        write_cfg(sactf_pkg::CFG_WAYS, sactf_pkg::GEO_W'($urandom_range(0, 7)));
        write_cfg(sactf_pkg::CFG_LINE_SIZE, sactf_pkg::GEO_W'($urandom_range(0, 7)));
      end
      for (i = 0; i < 6; i++) tag_pool[i] = 14'($urandom_range(0, 16383));
      for (i = 0; i < 4; i++) set_pool[i] = 8'($urandom_range(0, 255));
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // revisit a recent address, other byte in the line
          addr = recent[$urandom_range(0, 31)]
                 ^ sactf_pkg::ADDR_W'($urandom_range(0, 15));
        end else if (pick < 88) begin
          // small working set: few tags over few sets
          addr = {tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 3)],
                  4'($urandom_range(0, 15))};
        end else begin
          addr = sactf_pkg::ADDR_W'($urandom);
        end
        recent[recent_wr] = addr;
        recent_wr = (recent_wr + 1) % 32;
        send_access(addr, 1'b0, none);
        pace();
      end
    end

    // Drain and report
    in_valid <= 1'b0;
    while (lookups_due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: set_assoc_cache_tag_fifo_top.f
sv/sactf_pkg.sv
sv/sactf_tag_mem.sv
sv/sactf_ptr_mem.sv
sv/sactf_match.sv
sv/set_assoc_cache_tag_fifo_top.sv
bench/tb.sv
